/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/oaht_pkg.sv */
// Shared types and constants of the open-addressing hash table.
package oaht_pkg;

  // Field widths of the transaction payloads and registers
  localparam int unsigned KeyW      = 31;
  localparam int unsigned EntryW    = KeyW + 1;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned SlotW     = 10;
  localparam int unsigned CountW    = 11;
  localparam int unsigned TableSizeW = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned BitCntW   = $clog2(KeyW);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegTableSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegProbeMode = 2'd1;

  // Operation codes
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncSearch = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StInserted  = 2'd0;
  localparam logic [StatusW-1:0] StTableFull = 2'd1;
  localparam logic [StatusW-1:0] StFound     = 2'd2;
  localparam logic [StatusW-1:0] StNotFound  = 2'd3;

  // Reset value of the table size register
  localparam logic [TableSizeW-1:0] TableSizeReset = 11'd1024;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_PROBE = 4'b1000
  } state_e;

endpackage

/* hdl/oaht_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module oaht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one word, register one read word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/open_addressing_hash_table_unit.sv */
// Open-addressing hash table of 31-bit keys with linear or quadratic probing.
//
// For each transaction a bit-serial remainder unit first forms key mod table_size, then
// the slot RAM is read once per cycle along the probe sequence, the next address being
// formed while the current word is checked. An insert writes its slot in the same cycle
// as its result is loaded into the output register. After reset a clearing pass writes
// every one of the MAX_SLOTS entries empty, one per cycle, and no transaction is
// accepted during the pass; configuration writes are taken at all times and are meant to
// be made while the block is idle. A finished result waits in an output register while
// the next transaction is accepted and worked on.
module open_addressing_hash_table_unit #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [oaht_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [oaht_pkg::CfgDataW-1:0]     cfg_data_i,
  // Request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [oaht_pkg::KeyW-1:0]         key_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [oaht_pkg::StatusW-1:0]      status_o,
  output logic [oaht_pkg::SlotW-1:0]        slot_index_o,
  output logic [oaht_pkg::CountW-1:0]       probe_count_o
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned NW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 2);

  oaht_pkg::state_e state_q, state_d;

  logic [oaht_pkg::TableSizeW-1:0] table_size_q;
  logic                            probe_mode_q;

  logic                              func_q;
  logic [oaht_pkg::KeyW-1:0]         key_q;
  logic [NW-1:0]                     n_q;
  logic                              quad_q;
  logic [oaht_pkg::BitCntW-1:0]      bcnt_q;
  logic [NW-1:0]                     rem_q;
  logic [AW-1:0]                     idx_q;
  logic [AW-1:0]                     step_q;
  logic [CW-1:0]                     cnt_q;
  logic [AW-1:0]                     clr_addr_q;

  logic                              out_valid_q;
  logic [oaht_pkg::StatusW-1:0]      status_q;
  logic [oaht_pkg::SlotW-1:0]        slot_q;
  logic [oaht_pkg::CountW-1:0]       count_q;

  logic [NW-1:0]                     n_eff;
  logic                              in_acc;
  logic                              out_free;
  logic [NW:0]                       rem_sh;
  logic [NW-1:0]                     rem_nx;
  logic [NW:0]                       idx_sum;
  logic [AW-1:0]                     idx_nx;
  logic [NW:0]                       step_sum;
  logic [AW-1:0]                     step_nx;
  logic                              slot_full;
  logic                              key_eq;
  logic                              last_probe;
  logic                              probe_done;
  logic [oaht_pkg::StatusW-1:0]      res_status;
  logic [AW-1:0]                     res_slot;
  logic [CW-1:0]                     res_count;
  logic                              finish;

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [oaht_pkg::EntryW-1:0]       wr_data;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic [oaht_pkg::EntryW-1:0]       rd_data;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= oaht_pkg::TableSizeReset;
      probe_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        oaht_pkg::RegTableSize: table_size_q <= cfg_data_i;
        oaht_pkg::RegProbeMode: probe_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the table size into 1 .. MAX_SLOTS
  always_comb begin
    if (table_size_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(table_size_q) > MAX_SLOTS) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(table_size_q);
    end
  end

  assign in_ready_o = (state_q == oaht_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // One restoring step of key mod n per cycle, most significant key bit first
  assign rem_sh = {rem_q, key_q[bcnt_q]};
  assign rem_nx = (rem_sh >= (NW+1)'(n_q)) ? NW'(rem_sh - (NW+1)'(n_q)) : NW'(rem_sh);

  // Next probe address: add the step, fold back below n once
  assign idx_sum = (NW+1)'(idx_q) + (NW+1)'(step_q);
  assign idx_nx  = (idx_sum >= (NW+1)'(n_q)) ? AW'(idx_sum - (NW+1)'(n_q)) : AW'(idx_sum);

  // Quadratic step 2i+1 mod n advances by two; linear step stays
  assign step_sum = (NW+1)'(step_q) + (NW+1)'(2);
  always_comb begin
    if (!quad_q || n_q == NW'(1)) begin
      step_nx = step_q;
    end else if (step_sum >= (NW+1)'(n_q)) begin
      step_nx = AW'(step_sum - (NW+1)'(n_q));
    end else begin
      step_nx = AW'(step_sum);
    end
  end

  // Check the slot word read for the current probe
  assign slot_full  = rd_data[oaht_pkg::KeyW];
  assign key_eq     = (rd_data[oaht_pkg::KeyW-1:0] == key_q);
  assign last_probe = (cnt_q == CW'(n_q));

  always_comb begin
    probe_done = 1'b1;
    res_status = oaht_pkg::StNotFound;
    res_slot   = '0;
    res_count  = cnt_q;
    if (func_q == oaht_pkg::FuncInsert) begin
      if (!slot_full) begin
        res_status = oaht_pkg::StInserted;
        res_slot   = idx_q;
      end else if (last_probe) begin
        res_status = oaht_pkg::StTableFull;
        res_count  = cnt_q + CW'(1);
      end else begin
        probe_done = 1'b0;
      end
    end else begin
      if (slot_full && key_eq) begin
        res_status = oaht_pkg::StFound;
        res_slot   = idx_q;
      end else if (!slot_full) begin
        res_status = oaht_pkg::StNotFound;
      end else if (last_probe) begin
        res_count  = cnt_q + CW'(1);
      end else begin
        probe_done = 1'b0;
      end
    end
  end

  assign finish = (state_q == oaht_pkg::ST_PROBE) & probe_done & out_free;

  // Slot RAM ports: clearing sweep, insert write, probe reads
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = {1'b1, key_q};
    rd_en   = 1'b0;
    rd_addr = idx_nx;
    case (state_q)
      oaht_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_q;
        wr_data = '0;
      end
      oaht_pkg::ST_DIV: begin
        rd_en   = (bcnt_q == '0);
        rd_addr = AW'(rem_nx);
      end
      oaht_pkg::ST_PROBE: begin
        wr_en = finish & (func_q == oaht_pkg::FuncInsert) & ~slot_full;
        rd_en = ~probe_done;
      end
      default: ;
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      oaht_pkg::ST_CLEAR: begin
        if (clr_addr_q == AW'(MAX_SLOTS - 1)) begin
          state_d = oaht_pkg::ST_IDLE;
        end
      end
      oaht_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = oaht_pkg::ST_DIV;
        end
      end
      oaht_pkg::ST_DIV: begin
        if (bcnt_q == '0) begin
          state_d = oaht_pkg::ST_PROBE;
        end
      end
      oaht_pkg::ST_PROBE: begin
        if (finish) begin
          state_d = oaht_pkg::ST_IDLE;
        end
      end
      default: state_d = oaht_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaht_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == oaht_pkg::ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      out_valid_q <= finish | (out_valid_q & ~out_ready_i);
    end
  end

  // Working registers of the transaction in flight
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      key_q  <= key_i;
      n_q    <= n_eff;
      quad_q <= probe_mode_q;
      bcnt_q <= oaht_pkg::BitCntW'(oaht_pkg::KeyW - 1);
      rem_q  <= '0;
    end else if (state_q == oaht_pkg::ST_DIV) begin
      rem_q  <= rem_nx;
      bcnt_q <= bcnt_q - oaht_pkg::BitCntW'(1);
      if (bcnt_q == '0) begin
        idx_q  <= AW'(rem_nx);
        step_q <= (n_q == NW'(1)) ? '0 : AW'(1);
        cnt_q  <= CW'(1);
      end
    end else if (state_q == oaht_pkg::ST_PROBE && !probe_done) begin
      idx_q  <= idx_nx;
      step_q <= step_nx;
      cnt_q  <= cnt_q + CW'(1);
    end
  end

  // Result register, loaded when the walk ends and the register is free
  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q <= res_status;
      slot_q   <= oaht_pkg::SlotW'(res_slot);
      count_q  <= oaht_pkg::CountW'(res_count);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_index_o  = slot_q;
  assign probe_count_o = count_q;

  oaht_ram #(
    .WIDTH (oaht_pkg::EntryW),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

/* hdl/oaht_checker.sv */
// Port-level checker of the hash table unit and its bind.
`include "assert_macros.svh"

module oaht_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [oaht_pkg::StatusW-1:0]      status_o,
  input logic [oaht_pkg::SlotW-1:0]        slot_index_o,
  input logic [oaht_pkg::CountW-1:0]       probe_count_o
);

  logic [1:0] pending_q;
  logic       in_acc;
  logic       out_acc;
  logic       out_stall;
  logic       spurious;
  logic       failed;
  logic       bad_slot;
  logic       zero_count;
  logic [oaht_pkg::StatusW+oaht_pkg::SlotW+oaht_pkg::CountW-1:0] res_bus;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // Count transactions accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // Conditions watched by the assertions
  assign out_stall  = out_valid_o & ~out_ready_i;
  assign res_bus    = {status_o, slot_index_o, probe_count_o};
  assign spurious   = out_valid_o & (pending_q == 2'd0);
  assign failed     = out_valid_o & ((status_o == oaht_pkg::StTableFull) ||
                                     (status_o == oaht_pkg::StNotFound));
  assign bad_slot   = failed & (slot_index_o != '0);
  assign zero_count = out_valid_o & (probe_count_o == '0);

  property p_out_hold;
    out_stall |=> out_valid_o && $stable(res_bus);
  endproperty

  // A result waiting for the sink holds until taken
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, p_out_hold, "result changed while stalled")

  // Every result answers an accepted transaction
  `ASSERT_NEVER(a_no_spurious, clk_i, rst_ni, spurious, "result without a transaction")

  // Full table and miss report slot zero
  `ASSERT_NEVER(a_slot_zero, clk_i, rst_ni, bad_slot, "nonzero slot on a failed transaction")

  // Every walk probes at least one slot
  `ASSERT_NEVER(a_count_nonzero, clk_i, rst_ni, zero_count, "probe count of zero")

endmodule

bind open_addressing_hash_table_unit oaht_checker u_oaht_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the open-addressing hash table unit.
module testbench;

  localparam int unsigned MaxSlots     = 1024;
  localparam logic [oaht_pkg::KeyW-1:0] MaxKey = 31'd2147483646;
  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned HoldOff      = 500;
  localparam int unsigned SettleCycles = 100;

  // Register indexes beyond the list
  localparam logic [oaht_pkg::CfgIdxW-1:0] RegUnusedA = 2'd2;
  localparam logic [oaht_pkg::CfgIdxW-1:0] RegUnusedB = 2'd3;

  typedef struct packed {
    logic                      func;
    logic [oaht_pkg::KeyW-1:0] key;
  } request_t;

  typedef struct packed {
    logic [oaht_pkg::StatusW-1:0] status;
    logic [oaht_pkg::SlotW-1:0]   slot;
    logic [oaht_pkg::CountW-1:0]  probes;
  } lookup_t;

  // Clock, reset and block ports
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic [oaht_pkg::CfgIdxW-1:0]  cfg_index_i   = oaht_pkg::RegTableSize;
  logic [oaht_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          func_i        = oaht_pkg::FuncInsert;
  logic [oaht_pkg::KeyW-1:0]     key_i         = '0;
  logic                          out_ready_i   = 1'b0;
  logic                          cfg_ready_o;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic [oaht_pkg::StatusW-1:0]  status_o;
  logic [oaht_pkg::SlotW-1:0]    slot_index_o;
  logic [oaht_pkg::CountW-1:0]   probe_count_o;

  // Shadow copy of the slot store and the registers
  logic                          shadow_used [MaxSlots];
  logic [oaht_pkg::KeyW-1:0]     shadow_key  [MaxSlots];
  logic [oaht_pkg::CfgDataW-1:0] size_reg;
  logic                          mode_reg;

  // Transaction bookkeeping
  request_t                  request_backlog [$];
  lookup_t                   awaited_results [$];
  logic [oaht_pkg::KeyW-1:0] recent_keys [$];
  int unsigned     items_queued   = 0;
  int unsigned     results_checked = 0;
  int unsigned     error_count    = 0;

  // Sender and receiver pacing
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  logic        drain_hold    = 1'b0;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_seen  = 0;
  int unsigned holdoff_left  = 0;
  int unsigned pattern_left  = 0;
  int unsigned stall_pct     = 0;

  logic any_transfer;
  assign any_transfer = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                        (cfg_valid_i && cfg_ready_o);

  open_addressing_hash_table_unit #(
    .MAX_SLOTS(MaxSlots)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .probe_count_o(probe_count_o)
  );

  // Generate the clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Clamp the table size register to the usable range
  function automatic int unsigned slots_in_use();
    if (size_reg == '0) return 1;
    if (size_reg > MaxSlots) return MaxSlots;
    return int'(size_reg);
  endfunction

  // Slot visited at step i of the probe sequence
  function automatic int unsigned probe_at(longint unsigned key, longint unsigned i,
                                           int unsigned n);
    longint unsigned off;
    off = mode_reg ? i * i : i;
    return int'((key + off) % n);
  endfunction

  // Walk the probe sequence of one request and update the shadow store
  function automatic lookup_t hash_lookup(logic func, logic [oaht_pkg::KeyW-1:0] key);
    lookup_t     r;
    int unsigned n;
    int unsigned i;
    int unsigned idx;
    logic        done;
    n        = slots_in_use();
    r.slot   = '0;
    r.probes = oaht_pkg::CountW'(1);
    i        = 0;
    if (func == oaht_pkg::FuncInsert) begin
      idx = probe_at(key, 0, n);
      while (shadow_used[idx] && i < n) begin
        i++;
        idx      = probe_at(key, i, n);
        r.probes = r.probes + oaht_pkg::CountW'(1);
      end
      if (i < n) begin
        shadow_used[idx] = 1'b1;
        shadow_key[idx]  = key;
        r.status         = oaht_pkg::StInserted;
        r.slot           = oaht_pkg::SlotW'(idx);
      end else begin
        r.status = oaht_pkg::StTableFull;
      end
    end else begin
      r.status = oaht_pkg::StNotFound;
      done     = 1'b0;
      while (!done && i < n) begin
        idx = probe_at(key, i, n);
        if (shadow_used[idx] && shadow_key[idx] == key) begin
          r.status = oaht_pkg::StFound;
          r.slot   = oaht_pkg::SlotW'(idx);
          done     = 1'b1;
        end else if (!shadow_used[idx]) begin
          done = 1'b1;
        end else begin
          i++;
          r.probes = r.probes + oaht_pkg::CountW'(1);
        end
      end
    end
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Append a request to the backlog
  task automatic queue_item(input logic func, input logic [oaht_pkg::KeyW-1:0] key);
    request_backlog.push_back('{func: func, key: key});
    items_queued++;
  endtask

  // Hold until every queued request has produced its checked result
  task automatic wait_idle();
    while (results_checked < items_queued) @(posedge clk_i);
  endtask

  // Write one register over the configuration channel
  task automatic write_reg(input logic [oaht_pkg::CfgIdxW-1:0] idx,
                           input logic [oaht_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == oaht_pkg::RegTableSize) begin
      size_reg = val;
    end else if (idx == oaht_pkg::RegProbeMode) begin
      mode_reg = val[0];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Set both registers, then queue a run of random requests
  task automatic run_phase(input logic [oaht_pkg::CfgDataW-1:0] size_val,
                           input logic mode_val, input int unsigned count,
                           input logic hold);
    int unsigned               spread;
    logic                      func;
    logic [oaht_pkg::KeyW-1:0] key;
    write_reg(oaht_pkg::RegTableSize, size_val);
    write_reg(oaht_pkg::RegProbeMode, oaht_pkg::CfgDataW'(mode_val));
    recent_keys.delete();
    spread = (size_val == '0) ? 4 : int'(size_val) * 3;
    for (int unsigned k = 0; k < count; k++) begin
      func = ($urandom_range(9, 0) < 6) ? oaht_pkg::FuncInsert : oaht_pkg::FuncSearch;
      case ($urandom_range(3, 0))
        0:       key = oaht_pkg::KeyW'($urandom_range(MaxKey, 0));
        1:       key = (recent_keys.size() != 0) ?
                       recent_keys[$urandom_range(recent_keys.size() - 1, 0)] :
                       oaht_pkg::KeyW'($urandom_range(spread, 0));
        default: key = oaht_pkg::KeyW'($urandom_range(spread, 0));
      endcase
      if (func == oaht_pkg::FuncSearch && recent_keys.size() != 0 &&
          $urandom_range(1, 0) == 1) begin
        key = recent_keys[$urandom_range(recent_keys.size() - 1, 0)];
      end
      if (func == oaht_pkg::FuncInsert) begin
        recent_keys.push_back(key);
        if (recent_keys.size() > 64) void'(recent_keys.pop_front());
      end
      queue_item(func, key);
    end
    // Stall the result side for a long stretch while requests keep coming
    if (hold) begin
      repeat (200) @(posedge clk_i);
      holdoff_asked++;
    end
    wait_idle();
  endtask

  // Drive request transactions from the backlog in bursts
  always @(posedge clk_i) begin : request_driver
    logic     offer;
    request_t next_req;
    offer = in_valid_i;
    if (!rst_ni) begin
      offer = 1'b0;
    end else begin
      // Predict the result of an accepted transaction
      if (in_valid_i && in_ready_o) begin
        awaited_results.push_back(hash_lookup(func_i, key_i));
        offer = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 1);
          gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(45, 1);
          drain_hold = ($urandom_range(15, 0) == 0);
        end
      end
      // Offer the next transaction once the gap has run out
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          if (drain_hold && awaited_results.size() == 0) drain_hold = 1'b0;
          if (!drain_hold && request_backlog.size() != 0) begin
            next_req = request_backlog.pop_front();
            func_i  <= next_req.func;
            key_i   <= next_req.key;
            offer    = 1'b1;
          end
        end
      end
    end
    in_valid_i <= offer;
  end

  // Pace the result side: random stall density per stretch, plus long hold-offs
  always @(posedge clk_i) begin : result_receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (holdoff_seen != holdoff_asked) begin
        holdoff_seen = holdoff_asked;
        holdoff_left = HoldOff;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(300, 30);
        stall_pct    = $urandom_range(3, 0) * 28;
      end else begin
        pattern_left--;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    lookup_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d slot %0d probes %0d",
                             status_o, slot_index_o, probe_count_o));
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (status_o !== want.status)
          flag_error($sformatf("status %0d, predicted %0d", status_o, want.status));
        if (slot_index_o !== want.slot)
          flag_error($sformatf("slot_index %0d, predicted %0d", slot_index_o, want.slot));
        if (probe_count_o !== want.probes)
          flag_error($sformatf("probe_count %0d, predicted %0d", probe_count_o, want.probes));
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (any_transfer) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Reset, directed cases, random phases, then the verdict
  initial begin : stimulus
    for (int unsigned s = 0; s < MaxSlots; s++) begin
      shadow_used[s] = 1'b0;
      shadow_key[s]  = '0;
    end
    size_reg = oaht_pkg::TableSizeReset;
    mode_reg = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full table, linear: key extremes, a collision, hits and misses
    write_reg(oaht_pkg::RegTableSize, oaht_pkg::CfgDataW'(1024));
    write_reg(oaht_pkg::RegProbeMode, oaht_pkg::CfgDataW'(0));
    queue_item(oaht_pkg::FuncInsert, '0);
    queue_item(oaht_pkg::FuncInsert, MaxKey);
    queue_item(oaht_pkg::FuncSearch, '0);
    queue_item(oaht_pkg::FuncSearch, MaxKey);
    queue_item(oaht_pkg::FuncSearch, oaht_pkg::KeyW'(5));
    queue_item(oaht_pkg::FuncInsert, oaht_pkg::KeyW'(1024));
    queue_item(oaht_pkg::FuncSearch, oaht_pkg::KeyW'(1024));
    queue_item(oaht_pkg::FuncSearch, oaht_pkg::KeyW'(2048));
    wait_idle();

    // Size zero acts as one slot: full insert, hit, and a search that runs out
    write_reg(oaht_pkg::RegTableSize, '0);
    queue_item(oaht_pkg::FuncInsert, oaht_pkg::KeyW'(7));
    queue_item(oaht_pkg::FuncSearch, '0);
    queue_item(oaht_pkg::FuncSearch, oaht_pkg::KeyW'(9));
    wait_idle();

    // Writes to unused register indexes must change nothing
    write_reg(RegUnusedA, '1);
    write_reg(RegUnusedB, '0);
    queue_item(oaht_pkg::FuncSearch, '0);
    wait_idle();

    // Oversized table saturates; quadratic probing over the stale slots
    write_reg(oaht_pkg::RegTableSize, '1);
    write_reg(oaht_pkg::RegProbeMode, oaht_pkg::CfgDataW'(1));
    queue_item(oaht_pkg::FuncInsert, oaht_pkg::KeyW'(2048));
    queue_item(oaht_pkg::FuncSearch, oaht_pkg::KeyW'(2048));
    queue_item(oaht_pkg::FuncInsert, MaxKey);
    wait_idle();

    // Shrunk table: quadratic full with a free slot left, then linear fills it
    write_reg(oaht_pkg::RegTableSize, oaht_pkg::CfgDataW'(3));
    queue_item(oaht_pkg::FuncInsert, oaht_pkg::KeyW'(3));
    queue_item(oaht_pkg::FuncSearch, oaht_pkg::KeyW'(3));
    wait_idle();
    write_reg(oaht_pkg::RegProbeMode, oaht_pkg::CfgDataW'(0));
    queue_item(oaht_pkg::FuncInsert, oaht_pkg::KeyW'(3));
    queue_item(oaht_pkg::FuncSearch, oaht_pkg::KeyW'(3));
    queue_item(oaht_pkg::FuncInsert, oaht_pkg::KeyW'(4));
    wait_idle();

    // Random phases over several sizes and both probe modes
    run_phase(oaht_pkg::CfgDataW'(1024), 1'b0, 120, 1'b1);
    run_phase(oaht_pkg::CfgDataW'(13),   1'b1, 60,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(1),    1'b0, 30,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(2),    1'b1, 30,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(64),   1'b0, 80,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(1024), 1'b1, 120, 1'b1);
    run_phase(oaht_pkg::CfgDataW'(100),  1'b0, 80,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(31),   1'b1, 60,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(2047), 1'b1, 60,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(0),    1'b0, 20,  1'b0);
    run_phase(oaht_pkg::CfgDataW'($urandom_range(900, 150)), 1'b0, 80, 1'b0);
    run_phase(oaht_pkg::CfgDataW'(7),    1'b1, 40,  1'b0);
    run_phase(oaht_pkg::CfgDataW'(1024), 1'b0, 120, 1'b0);

    // Let any stray result show up before the verdict
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/oaht_pkg.sv
hdl/oaht_ram.sv
hdl/open_addressing_hash_table_unit.sv
hdl/oaht_checker.sv
verif/testbench.sv
